// ===== src/dwtad_pkg.sv =====
// Package for the dual-window temperature anomaly detector.
// Holds window sizing, operation and state codes, register indexes and
// the window status record. No dependencies.
package dwtad_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int SAMPLE_W = 12;
  localparam int DELTA_W = SAMPLE_W + 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int MIN_W = 5;
  localparam int CMP_W = (CNT_W > MIN_W) ? CNT_W : MIN_W;
  localparam int IVL_W = 8;
  localparam int THR_W = 16;
  localparam int DUR_OUT_W = 12;
  localparam int DUR_W = ((CNT_W + IVL_W) > DUR_OUT_W) ? (CNT_W + IVL_W) : DUR_OUT_W;
  localparam int PROD1_W = THR_W + CNT_W;
  localparam int RHS_W = PROD1_W + IVL_W;
  localparam int LHS_W = SAMPLE_W + 6;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_PRIMARY   = 2'd0,
    OP_SECONDARY = 2'd1,
    OP_CLEAR     = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_NORMAL    = 2'd0,
    ST_WARM_LOAD = 2'd1,
    ST_FRIDGE    = 2'd2,
    ST_FREEZER   = 2'd3
  } anomaly_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_SAMPLES  = 3'd0,
    REG_POLL_IVL     = 3'd1,
    REG_SLOPE_THR    = 3'd2,
    REG_FRIDGE_LIM   = 3'd3,
    REG_FREEZER_LIM  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_MUL1,
    SEQ_MUL2,
    SEQ_DECIDE
  } seq_state_t;

  typedef struct packed {
    logic [CNT_W-1:0]          count;
    logic                      ready;
    logic                      over;
    logic signed [SAMPLE_W-1:0] newest;
    logic signed [DELTA_W-1:0]  delta;
  } win_status_t;

endpackage

// ===== src/dwtad_cell.sv =====
// One stage of a sample window shift line.
// Depends on dwtad_pkg for the sample width.
module dwtad_cell (
  input  logic                                  clk,
  input  logic                                  shift,
  input  logic signed [dwtad_pkg::SAMPLE_W-1:0] din,
  output logic signed [dwtad_pkg::SAMPLE_W-1:0] dout
);

  logic signed [dwtad_pkg::SAMPLE_W-1:0] value;

  always_ff @(posedge clk) begin
    if (shift) begin
      value <= din;
    end
  end

  assign dout = value;

endmodule

// ===== src/dwtad_window.sv =====
// Sliding window of one sensor: a chain of dwtad_cell stages, fill count,
// first-sample register and the readiness and last-three checks.
// Depends on dwtad_pkg and dwtad_cell.
module dwtad_window (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  input  logic                                  clear,
  input  logic signed [dwtad_pkg::SAMPLE_W-1:0] sample,
  input  logic [dwtad_pkg::MIN_W-1:0]           min_samples,
  input  logic signed [dwtad_pkg::SAMPLE_W-1:0] limit,
  output dwtad_pkg::win_status_t                status
);

  localparam int DEPTH = dwtad_pkg::WINDOW_DEPTH;

  logic signed [dwtad_pkg::SAMPLE_W-1:0] tap [DEPTH];
  logic [dwtad_pkg::CNT_W-1:0]           count;
  logic [dwtad_pkg::CNT_W-1:0]           count_next;
  logic signed [dwtad_pkg::SAMPLE_W-1:0] first;
  logic signed [dwtad_pkg::SAMPLE_W-1:0] oldest;
  logic [dwtad_pkg::CMP_W-1:0]           need;
  logic                                  full;

  // Tap 0 holds the newest sample, tap k the sample k pushes back.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      dwtad_cell u_cell (.clk(clk), .shift(push), .din(sample), .dout(tap[k]));
    end else begin : g_body
      dwtad_cell u_cell (.clk(clk), .shift(push), .din(tap[k-1]), .dout(tap[k]));
    end
  end

  assign full = (count == dwtad_pkg::CNT_W'(DEPTH));

  always_comb begin
    count_next = count;
    if (clear) begin
      count_next = '0;
    end else if (push && !full) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Hold the first sample since the window was empty; it is the oldest
  // entry until the window fills, then the last tap takes over.
  always_ff @(posedge clk) begin
    if (push && (count == '0)) begin
      first <= sample;
    end
  end

  assign oldest = full ? tap[DEPTH-1] : first;
  assign need = (min_samples == '0) ? dwtad_pkg::CMP_W'(1)
                                    : dwtad_pkg::CMP_W'(min_samples);

  always_comb begin
    status.count  = count;
    status.ready  = (dwtad_pkg::CMP_W'(count) >= need);
    status.newest = tap[0];
    status.delta  = {tap[0][dwtad_pkg::SAMPLE_W-1], tap[0]}
                  - {oldest[dwtad_pkg::SAMPLE_W-1], oldest};
    status.over   = (tap[0] > limit)
                 && ((count < dwtad_pkg::CNT_W'(2)) || (tap[1] > limit))
                 && ((count < dwtad_pkg::CNT_W'(3)) || (tap[2] > limit));
  end

endmodule

// ===== src/dual_window_temperature_anomaly_detector.sv =====
// Top level of the dual-window temperature anomaly detector.
// Depends on dwtad_pkg and dwtad_window (which uses dwtad_cell).
//
// Each transaction on the input stream is a primary sample, a secondary
// sample, a clear or the unused operation, and yields exactly one result
// transaction. An item is accepted in the idle state, and the acceptance
// edge pushes a sample into its sensor's cell chain. State MUL1 then forms
// threshold times count, MUL2 multiplies the product by the poll interval,
// and the decision stage loads the output register. Items are worked one at
// a time, so no new item is taken before the last result is handed on: a new
// item is taken in the cycle after the decision stage has handed its result
// to the output register, which may still be waiting on m_tready. While that
// register holds an unread result, the decision stage and the input stall.
// Each window is a shift line of 16 cells with a fill count, so reset needs
// no clearing pass. Registers are written through cfg_we; the user must do
// so only while idle, which the block itself does not enforce.
module dual_window_temperature_anomaly_detector (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_we,
  input  logic [dwtad_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dwtad_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [15:0]                           s_tdata,  // [11:0] sample
  input  logic [1:0]                            s_tuser,  // [1:0] operation
  // result stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // [1:0] current_state, [2] event_valid, [4:3] event_kind,
  // [16:5] event_temperature, [29:17] event_delta, [41:30] event_duration,
  // [42] event_secondary, [47:43] zero
  output logic [47:0]                           m_tdata
);

  localparam int SW = dwtad_pkg::SAMPLE_W;

  // configuration registers
  logic [dwtad_pkg::MIN_W-1:0]  min_samples;
  logic [dwtad_pkg::IVL_W-1:0]  poll_interval_s;
  logic [dwtad_pkg::THR_W-1:0]  slope_threshold;
  logic signed [SW-1:0]         fridge_limit;
  logic signed [SW-1:0]         freezer_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_samples     <= dwtad_pkg::MIN_W'(3);
      poll_interval_s <= dwtad_pkg::IVL_W'(1);
      slope_threshold <= dwtad_pkg::THR_W'(52);
      fridge_limit    <= SW'(128);
      freezer_limit   <= -SW'(160);
    end else if (cfg_we) begin
      case (cfg_index)
        dwtad_pkg::REG_MIN_SAMPLES: min_samples     <= cfg_data[dwtad_pkg::MIN_W-1:0];
        dwtad_pkg::REG_POLL_IVL:    poll_interval_s <= cfg_data[dwtad_pkg::IVL_W-1:0];
        dwtad_pkg::REG_SLOPE_THR:   slope_threshold <= cfg_data[dwtad_pkg::THR_W-1:0];
        dwtad_pkg::REG_FRIDGE_LIM:  fridge_limit    <= cfg_data[SW-1:0];
        dwtad_pkg::REG_FREEZER_LIM: freezer_limit   <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  dwtad_pkg::seq_state_t state;
  dwtad_pkg::seq_state_t state_next;
  logic                  accept;
  logic                  out_free;
  logic                  load_out;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      dwtad_pkg::SEQ_IDLE:   if (s_tvalid) state_next = dwtad_pkg::SEQ_MUL1;
      dwtad_pkg::SEQ_MUL1:   state_next = dwtad_pkg::SEQ_MUL2;
      dwtad_pkg::SEQ_MUL2:   state_next = dwtad_pkg::SEQ_DECIDE;
      dwtad_pkg::SEQ_DECIDE: if (out_free) state_next = dwtad_pkg::SEQ_IDLE;
      default:               state_next = dwtad_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == dwtad_pkg::SEQ_IDLE);
    load_out = (state == dwtad_pkg::SEQ_DECIDE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dwtad_pkg::SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the operation, push or clear the windows at acceptance
  dwtad_pkg::op_t        op;
  dwtad_pkg::op_t        in_op;
  logic signed [SW-1:0]  in_sample;

  assign in_op     = dwtad_pkg::op_t'(s_tuser);
  assign in_sample = s_tdata[SW-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= in_op;
    end
  end

  dwtad_pkg::win_status_t pst;
  dwtad_pkg::win_status_t sst;

  dwtad_window u_primary (
    .clk(clk), .rst(rst),
    .push(accept && (in_op == dwtad_pkg::OP_PRIMARY)),
    .clear(accept && (in_op == dwtad_pkg::OP_CLEAR)),
    .sample(in_sample), .min_samples(min_samples), .limit(fridge_limit),
    .status(pst)
  );

  dwtad_window u_secondary (
    .clk(clk), .rst(rst),
    .push(accept && (in_op == dwtad_pkg::OP_SECONDARY)),
    .clear(accept && (in_op == dwtad_pkg::OP_CLEAR)),
    .sample(in_sample), .min_samples(min_samples), .limit(freezer_limit),
    .status(sst)
  );

  // multiply stages
  logic [dwtad_pkg::PROD1_W-1:0] thr_cnt;
  logic [dwtad_pkg::RHS_W-1:0]   rhs;
  logic [dwtad_pkg::DUR_W-1:0]   pdur;
  logic [dwtad_pkg::DUR_W-1:0]   sdur;

  always_ff @(posedge clk) begin
    if (state == dwtad_pkg::SEQ_MUL1) begin
      thr_cnt <= dwtad_pkg::PROD1_W'(slope_threshold) * dwtad_pkg::PROD1_W'(pst.count);
      pdur    <= dwtad_pkg::DUR_W'(pst.count) * dwtad_pkg::DUR_W'(poll_interval_s);
    end
    if (state == dwtad_pkg::SEQ_MUL2) begin
      rhs  <= dwtad_pkg::RHS_W'(thr_cnt) * dwtad_pkg::RHS_W'(poll_interval_s);
      sdur <= dwtad_pkg::DUR_W'(sst.count) * dwtad_pkg::DUR_W'(poll_interval_s);
    end
  end

  // decision
  dwtad_pkg::anomaly_t                anomaly;
  dwtad_pkg::anomaly_t                nxt;
  dwtad_pkg::anomaly_t                cur;
  logic                               slope_hit;
  logic                               ev_valid;
  logic                               ev_sec;
  logic signed [SW-1:0]               ev_temp;
  logic signed [dwtad_pkg::DELTA_W-1:0] ev_delta;
  logic [dwtad_pkg::DUR_OUT_W-1:0]    ev_dur;
  logic [dwtad_pkg::LHS_W-1:0]        lhs;

  // delta*64 > rhs can only hold for a positive delta, which fits in SW bits
  assign lhs = {pst.delta[SW-1:0], 6'b0};
  assign slope_hit = !pst.delta[dwtad_pkg::DELTA_W-1] && (pst.delta != '0)
                  && (dwtad_pkg::RHS_W'(lhs) > rhs);

  always_comb begin
    nxt      = dwtad_pkg::ST_NORMAL;
    ev_temp  = '0;
    ev_delta = '0;
    ev_dur   = '0;
    ev_sec   = 1'b0;
    ev_valid = 1'b0;
    cur      = anomaly;
    if (op == dwtad_pkg::OP_CLEAR) begin
      cur = dwtad_pkg::ST_NORMAL;
    end else if (op == dwtad_pkg::OP_PRIMARY || op == dwtad_pkg::OP_SECONDARY) begin
      if (pst.ready) begin
        if (slope_hit) begin
          nxt = dwtad_pkg::ST_WARM_LOAD;
        end else if (pst.over) begin
          nxt = dwtad_pkg::ST_FRIDGE;
        end
        if (nxt != dwtad_pkg::ST_NORMAL) begin
          ev_temp  = pst.newest;
          ev_delta = pst.delta;
          ev_dur   = pdur[dwtad_pkg::DUR_OUT_W-1:0];
        end
      end
      if (nxt == dwtad_pkg::ST_NORMAL && sst.ready && sst.over) begin
        nxt     = dwtad_pkg::ST_FREEZER;
        ev_temp = sst.newest;
        ev_dur  = sdur[dwtad_pkg::DUR_OUT_W-1:0];
        ev_sec  = 1'b1;
      end
      ev_valid = (nxt != anomaly);
      cur      = nxt;
    end
    // drop the event record when the state did not change
    if (!ev_valid) begin
      nxt      = dwtad_pkg::ST_NORMAL;
      ev_temp  = '0;
      ev_delta = '0;
      ev_dur   = '0;
      ev_sec   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anomaly <= dwtad_pkg::ST_NORMAL;
    end else if (load_out) begin
      anomaly <= cur;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {5'b0, ev_sec, ev_dur, ev_delta, ev_temp, nxt, ev_valid, cur};
    end
  end

endmodule

// ===== sim/dual_window_temperature_anomaly_detector_tb.sv =====
// Self-checking bench for dual_window_temperature_anomaly_detector: directed and random
// sample streams with a cycle-free predictor, bursty input, stalling output.
// Depends on dwtad_pkg and the detector RTL.
`timescale 1ns / 1ps

module dual_window_temperature_anomaly_detector_tb;
  import dwtad_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SHOWN_ERRORS = 10;

  // result layout, lowest bits last
  typedef struct packed {
    logic [4:0]         pad;
    logic               secondary;
    logic [11:0]        duration;
    logic signed [12:0] delta;
    logic signed [11:0] temperature;
    anomaly_t           kind;
    logic               raised;
    anomaly_t           state;
  } report_t;

  typedef struct packed {
    logic [4:0]         min_samples;
    logic [7:0]         interval;
    logic [15:0]        threshold;
    logic signed [11:0] fridge;
    logic signed [11:0] freezer;
  } limits_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  dual_window_temperature_anomaly_detector DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state: index 0 primary sensor, 1 secondary sensor
  int       win_data [2][WINDOW_DEPTH];
  int       win_count [2];
  int       win_head [2];
  anomaly_t alarm_state;
  limits_t  active_limits;

  report_t  expected_reports [$];
  int       fail_count = 0;
  int       results_seen = 0;
  int       config_writes = 0;
  int       op_tally [4];
  int       event_tally [4];
  int       hold_off_left = 0;
  int       burst_left = 0;
  int       trend_level [2];
  int       trend_rate [2];

  // expected results, oldest first
  function automatic void queue_report(input report_t r);
    expected_reports.insert(expected_reports.size(), r);
  endfunction

  function automatic report_t take_report();
    report_t r;
    r = expected_reports[0];
    expected_reports.delete(0);
    return r;
  endfunction

  function automatic int window_back(input int sensor, input int k);
    return win_data[sensor][(win_head[sensor] + WINDOW_DEPTH - 1 - k) % WINDOW_DEPTH];
  endfunction

  function automatic bit last_three_over(input int sensor, input int limit);
    int span;
    span = (win_count[sensor] < 3) ? win_count[sensor] : 3;
    for (int k = 0; k < span; k++)
      if (window_back(sensor, k) <= limit) return 1'b0;
    return 1'b1;
  endfunction

  // Advance the predicted detector by one reading and return its report.
  function automatic report_t apply_reading(input op_t op, input logic signed [11:0] temp);
    report_t  r;
    anomaly_t next_state;
    int       need, n, sensor, newest, delta, ev_temp, ev_delta, ev_dur;
    longint   lhs, rhs;
    bit       raised, from_freezer;
    r = '0;
    next_state = ST_NORMAL;
    ev_temp = 0;
    ev_delta = 0;
    ev_dur = 0;
    raised = 1'b0;
    from_freezer = 1'b0;
    need = (active_limits.min_samples == 5'd0) ? 1 : int'(active_limits.min_samples);
    case (op)
      OP_CLEAR: begin
        win_count = '{0, 0};
        win_head = '{0, 0};
        alarm_state = ST_NORMAL;
      end
      OP_PRIMARY, OP_SECONDARY: begin
        sensor = (op == OP_SECONDARY) ? 1 : 0;
        win_data[sensor][win_head[sensor]] = temp;
        win_head[sensor] = (win_head[sensor] + 1) % WINDOW_DEPTH;
        if (win_count[sensor] < WINDOW_DEPTH) win_count[sensor]++;

        if (win_count[0] >= need) begin
          n = win_count[0];
          newest = window_back(0, 0);
          delta = newest - window_back(0, n - 1);
          lhs = longint'(delta) * 64;
          rhs = longint'(active_limits.threshold) * n * int'(active_limits.interval);
          if (lhs > rhs) next_state = ST_WARM_LOAD;
          else if (last_three_over(0, int'(active_limits.fridge))) next_state = ST_FRIDGE;
          if (next_state != ST_NORMAL) begin
            ev_temp = newest;
            ev_delta = delta;
            ev_dur = n * int'(active_limits.interval);
          end
        end
        // freezer check only when the primary side is quiet
        if (next_state == ST_NORMAL && win_count[1] >= need &&
            last_three_over(1, int'(active_limits.freezer))) begin
          next_state = ST_FREEZER;
          ev_temp = window_back(1, 0);
          ev_delta = 0;
          ev_dur = win_count[1] * int'(active_limits.interval);
          from_freezer = 1'b1;
        end
        if (next_state != alarm_state) begin
          alarm_state = next_state;
          raised = 1'b1;
        end
      end
      default: ;
    endcase
    r.state = alarm_state;
    if (raised) begin
      r.raised = 1'b1;
      r.kind = next_state;
      r.temperature = 12'(ev_temp);
      r.delta = 13'(ev_delta);
      r.duration = 12'(ev_dur);
      r.secondary = from_freezer;
    end
    return r;
  endfunction

  function automatic string describe(input report_t r);
    return $sformatf("state=%0d ev=%0b kind=%0d temp=%0d delta=%0d dur=%0d sec=%0b pad=%h",
                     r.state, r.raised, r.kind, r.temperature, r.delta, r.duration,
                     r.secondary, r.pad);
  endfunction

  function automatic string diff_fields(input report_t want, input report_t seen);
    string d;
    d = "";
    if (seen.state !== want.state) d = {d, " current_state"};
    if (seen.raised !== want.raised) d = {d, " event_valid"};
    if (seen.kind !== want.kind) d = {d, " event_kind"};
    if (seen.temperature !== want.temperature) d = {d, " event_temperature"};
    if (seen.delta !== want.delta) d = {d, " event_delta"};
    if (seen.duration !== want.duration) d = {d, " event_duration"};
    if (seen.secondary !== want.secondary) d = {d, " event_secondary"};
    if (seen.pad !== want.pad) d = {d, " pad"};
    return d;
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= SHOWN_ERRORS) $display("ERROR @%0t: %s", $realtime, what);
  endtask

  // result checker: compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    report_t seen, want;
    string   diffs;
    if (!rst && m_tvalid && m_tready) begin
      seen = report_t'(m_tdata);
      results_seen++;
      if (expected_reports.size() == 0) begin
        note_failure({"result with nothing pending: ", describe(seen)});
      end else begin
        want = take_report();
        diffs = diff_fields(want, seen);
        if (diffs != "")
          note_failure($sformatf("result %0d differs in%s\n  expected %s\n  actual   %s",
                                 results_seen, diffs, describe(want), describe(seen)));
      end
    end
  end

  // output side: long hold-off on request, otherwise changing stall styles
  initial begin : result_sink
    int style, style_left, tick;
    style = 0;
    style_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_off_left > 0) begin
        m_tready = 1'b0;
        hold_off_left--;
      end else begin
        if (style_left == 0) begin
          style = $urandom_range(0, 3);
          style_left = $urandom_range(20, 120);
        end
        style_left--;
        case (style)
          0: m_tready = 1'b1;
          1: m_tready = ($urandom_range(0, 3) != 0);
          2: m_tready = ($urandom_range(0, 9) < 3);
          default: m_tready = tick[0];
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
             STALL_LIMIT, expected_reports.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic offer_reading(input op_t op, input logic signed [11:0] temp);
    report_t want;
    int      gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser = op;
    s_tdata = {4'b0000, temp};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    want = apply_reading(op, temp);
    queue_report(want);
    op_tally[int'(op)]++;
    if (want.raised) event_tally[int'(want.kind)]++;
  endtask

  // Random reading: mostly trending sensor values, with jumps, limit hugging and noise.
  task automatic offer_random();
    op_t op;
    int  roll, sensor, lim;
    logic signed [11:0] temp;
    roll = $urandom_range(0, 99);
    if (roll < 55) op = OP_PRIMARY;
    else if (roll < 92) op = OP_SECONDARY;
    else if (roll < 96) op = OP_CLEAR;
    else op = OP_NONE;
    sensor = (op == OP_SECONDARY) ? 1 : 0;
    lim = (sensor == 1) ? int'(active_limits.freezer) : int'(active_limits.fridge);
    if ($urandom_range(0, 19) == 0) trend_rate[sensor] = $urandom_range(0, 90) - 30;
    roll = $urandom_range(0, 99);
    if (roll < 6) trend_level[sensor] = $urandom_range(0, 4095) - 2048;
    else if (roll < 12) trend_level[sensor] = lim + $urandom_range(0, 6) - 3;
    else if (roll < 14) trend_level[sensor] = 2047;
    else if (roll < 16) trend_level[sensor] = -2048;
    else trend_level[sensor] += trend_rate[sensor] + $urandom_range(0, 8) - 4;
    if (trend_level[sensor] > 2047) trend_level[sensor] = 2047;
    if (trend_level[sensor] < -2048) trend_level[sensor] = -2048;
    if (op == OP_CLEAR || op == OP_NONE) temp = 12'($urandom_range(0, 4095));
    else temp = 12'(trend_level[sensor]);
    offer_reading(op, temp);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    config_writes++;
    case (idx)
      REG_MIN_SAMPLES: active_limits.min_samples = value[4:0];
      REG_POLL_IVL:    active_limits.interval = value[7:0];
      REG_SLOPE_THR:   active_limits.threshold = value;
      REG_FRIDGE_LIM:  active_limits.fridge = value[11:0];
      REG_FREEZER_LIM: active_limits.freezer = value[11:0];
      default: ;
    endcase
  endtask

  // Reprogram only once the detector is idle.
  task automatic load_limits(input limits_t lim);
    wait_drained();
    repeat (6) @(posedge clk);
    write_register(REG_MIN_SAMPLES, {11'd0, lim.min_samples});
    write_register(REG_POLL_IVL, {8'd0, lim.interval});
    write_register(REG_SLOPE_THR, lim.threshold);
    write_register(REG_FRIDGE_LIM, {{4{lim.fridge[11]}}, lim.fridge});
    write_register(REG_FREEZER_LIM, {{4{lim.freezer[11]}}, lim.freezer});
    trend_level = '{int'(lim.fridge), int'(lim.freezer)};
    trend_rate = '{$urandom_range(0, 40) - 10, $urandom_range(0, 20) - 10};
  endtask

  function automatic limits_t corner_limits(input int idx);
    case (idx)
      0: return '{5'd1, 8'd1, 16'd0, 12'sd0, -12'sd2048};
      1: return '{5'd16, 8'd255, 16'hFFFF, 12'sd2047, 12'sd2047};
      2: return '{5'd0, 8'd2, 16'd10, -12'sd2048, 12'sd0};
      3: return '{5'd17, 8'd10, 16'd5, 12'sd100, -12'sd100};
      4: return '{5'd31, 8'd1, 16'd0, -12'sd2048, -12'sd2048};
      5: return '{5'd2, 8'd128, 16'd1, 12'sd50, -12'sd300};
      6: return '{5'd16, 8'd1, 16'd52, 12'sd128, -12'sd160};
      default: return '{5'd5, 8'd255, 16'd0, 12'sd300, -12'sd20};
    endcase
  endfunction

  function automatic limits_t random_limits();
    limits_t lim;
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) lim.min_samples = 5'd0;
    else if (roll == 1) lim.min_samples = 5'($urandom_range(17, 31));
    else lim.min_samples = 5'($urandom_range(1, 16));
    lim.interval = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 4))
                                               : 8'($urandom_range(1, 255));
    roll = $urandom_range(0, 9);
    if (roll < 5) lim.threshold = 16'($urandom_range(0, 120));
    else if (roll < 8) lim.threshold = 16'($urandom_range(0, 2000));
    else lim.threshold = 16'($urandom_range(0, 65535));
    lim.fridge = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
                                             : 12'($urandom_range(0, 800) - 400);
    lim.freezer = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
                                              : 12'($urandom_range(0, 800) - 400);
    return lim;
  endfunction

  // Reset limits: warm load, fridge overheat, freezer warning, return to normal,
  // clear, unused operation, sample extremes.
  task automatic test_default_thresholds();
    offer_reading(OP_NONE, 12'h5A5);
    offer_reading(OP_SECONDARY, -12'sd100);
    offer_reading(OP_PRIMARY, 12'sd0);
    offer_reading(OP_PRIMARY, 12'sd10);
    offer_reading(OP_PRIMARY, 12'sd20);
    offer_reading(OP_PRIMARY, 12'sd20);
    offer_reading(OP_PRIMARY, 12'sd2047);
    offer_reading(OP_PRIMARY, -12'sd2048);
    offer_reading(OP_CLEAR, 12'h000);
    offer_reading(OP_PRIMARY, 12'sd200);
    offer_reading(OP_PRIMARY, 12'sd200);
    offer_reading(OP_PRIMARY, 12'sd200);
    offer_reading(OP_PRIMARY, 12'sd100);
    offer_reading(OP_SECONDARY, -12'sd100);
    offer_reading(OP_SECONDARY, -12'sd100);
    offer_reading(OP_SECONDARY, -12'sd100);
    offer_reading(OP_SECONDARY, -12'sd2048);
    offer_reading(OP_CLEAR, 12'hFFF);
    offer_reading(OP_NONE, 12'h000);
    offer_reading(OP_SECONDARY, 12'sd2047);
  endtask

  // Windows analyzed from one sample: the three-sample checks use what is held.
  task automatic test_short_windows();
    limits_t lim;
    lim = '{5'd1, 8'd7, 16'd52, 12'sd128, -12'sd160};
    load_limits(lim);
    offer_reading(OP_CLEAR, 12'h000);
    offer_reading(OP_PRIMARY, 12'sd300);
    offer_reading(OP_PRIMARY, 12'sd300);
    offer_reading(OP_SECONDARY, -12'sd100);
    offer_reading(OP_CLEAR, 12'h000);
    offer_reading(OP_SECONDARY, -12'sd100);
    offer_reading(OP_SECONDARY, -12'sd100);
    offer_reading(OP_PRIMARY, 12'sd0);
  endtask

  task automatic test_register_corners();
    for (int i = 0; i < 8; i++) begin
      load_limits(corner_limits(i));
      repeat (100) offer_random();
    end
  endtask

  // Hold the result side off while the sender keeps offering, so the input stalls.
  task automatic test_output_backpressure();
    load_limits(random_limits());
    hold_off_left = 200;
    repeat (40) offer_random();
  endtask

  task automatic test_sender_pause();
    repeat (15) offer_random();
    wait_drained();
    repeat (15) offer_random();
  endtask

  task automatic test_random_traffic();
    int pause_at;
    for (int phase = 0; phase < 10; phase++) begin
      load_limits(random_limits());
      pause_at = $urandom_range(10, 100);
      for (int i = 0; i < 110; i++) begin
        if (i == pause_at) wait_drained();
        offer_random();
      end
    end
  endtask

  initial begin : run
    win_count = '{0, 0};
    win_head = '{0, 0};
    alarm_state = ST_NORMAL;
    active_limits = '{5'd3, 8'd1, 16'd52, 12'sd128, -12'sd160};
    op_tally = '{0, 0, 0, 0};
    event_tally = '{0, 0, 0, 0};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_thresholds();
    test_short_windows();
    test_register_corners();
    test_output_backpressure();
    test_sender_pause();
    test_random_traffic();

    wait_drained();
    repeat (16) @(posedge clk);
    if (expected_reports.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_reports.size()));
    $display("Covered %0d readings (primary %0d, secondary %0d, clear %0d, unused %0d),",
             op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3], op_tally[0], op_tally[1],
             op_tally[2], op_tally[3]);
    $display("%0d register writes; events: normal %0d, warm load %0d, fridge %0d, freezer %0d",
             config_writes, event_tally[0], event_tally[1], event_tally[2], event_tally[3]);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== dual_window_temperature_anomaly_detector.f =====
src/dwtad_pkg.sv
src/dwtad_cell.sv
src/dwtad_window.sv
src/dual_window_temperature_anomaly_detector.sv
sim/dual_window_temperature_anomaly_detector_tb.sv
